### design/bgnc_pkg.sv
// Shared types, constants and sizes for the binary grid neighbor count block.
`timescale 1ns / 1ps

package bgnc_pkg;

    localparam int MAX_SIZE   = 32;
    localparam int SIZE_W     = 6;
    localparam int POS_W      = $clog2(MAX_SIZE);
    localparam int COUNT_W    = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = SIZE_W'(8);

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SIZE_W-1:0]  size_t;

    // [1]: bit two rows back, [0]: bit one row back (or the row just filled)
    typedef logic [1:0] line_t;

    // column sum of up to three bits
    typedef logic [1:0] colsum_t;

    typedef struct packed {
        count_t mine_count;
        pos_t   cell_row;
        pos_t   cell_col;
        logic   last_of_run;
        logic   field_done;
    } result_t;

    typedef struct packed {
        logic valid;
        logic flush;
        pos_t col;
        pos_t row;
        logic mine;
        logic emit;
        logic last_col;
        logic final_cell;
        logic mask_one;
        logic mask_two;
    } issue_t;

    typedef struct packed {
        logic take;
        logic final_go;
        logic final_held;
    } win_status_t;

endpackage

### design/bgnc_line_mem.sv
// Column-indexed line memory holding the two previous rows, with a registered read.
`timescale 1ns / 1ps

module bgnc_line_mem (
    input  logic            clk,
    input  logic            rd_en,
    input  bgnc_pkg::pos_t  rd_addr,
    output bgnc_pkg::line_t rd_data,
    input  logic            wr_en,
    input  bgnc_pkg::pos_t  wr_addr,
    input  bgnc_pkg::line_t wr_data
);
    import bgnc_pkg::*;

    line_t line_mem [MAX_SIZE];
    line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/bgnc_window.sv
// Window stage: column sums, sliding 3x3 counts, line write-back and result push.
`timescale 1ns / 1ps

module bgnc_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgnc_pkg::issue_t      issue,
    input  bgnc_pkg::line_t       rd_data,
    input  logic                  room2,
    output bgnc_pkg::win_status_t status,
    output logic                  wr_en,
    output bgnc_pkg::pos_t        wr_addr,
    output bgnc_pkg::line_t       wr_data,
    output logic                  push0,
    output logic                  push1,
    output bgnc_pkg::result_t     res0,
    output bgnc_pkg::result_t     res1
);
    import bgnc_pkg::*;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    issue_t  s1_reg;
    colsum_t m1_reg;
    colsum_t m2_reg;

    logic    go;
    logic    take;
    logic    two_bit;
    logic    one_bit;
    colsum_t colsum;
    colsum_t m1_eff;
    colsum_t m2_eff;
    logic    emit_a;
    logic    emit_b;
    result_t res_a;
    result_t res_b;

    always_comb
    begin
        go      = s1_valid_reg && room2;
        take    = !s1_valid_reg || go;
        two_bit = s1_reg.mask_two ? 1'b0 : rd_data[1];
        one_bit = s1_reg.mask_one ? 1'b0 : rd_data[0];
        colsum  = colsum_t'({1'b0, two_bit}) + colsum_t'({1'b0, one_bit})
                + colsum_t'({1'b0, s1_reg.mine});
        m1_eff  = (s1_reg.col == '0) ? '0 : m1_reg;
        m2_eff  = (s1_reg.col[POS_W-1:1] == '0) ? '0 : m2_reg;
        emit_a  = s1_reg.emit && (s1_reg.col != '0);
        emit_b  = s1_reg.emit && s1_reg.last_col;

        res_a.mine_count  = COUNT_W'(m2_eff) + COUNT_W'(m1_eff) + COUNT_W'(colsum);
        res_a.cell_row    = s1_reg.row;
        res_a.cell_col    = s1_reg.col - POS_W'(1);
        res_a.last_of_run = !s1_reg.last_col && !s1_reg.flush && !s1_reg.final_cell;
        res_a.field_done  = 1'b0;

        res_b.mine_count  = COUNT_W'(m1_eff) + COUNT_W'(colsum);
        res_b.cell_row    = s1_reg.row;
        res_b.cell_col    = s1_reg.col;
        res_b.last_of_run = !s1_reg.final_cell;
        res_b.field_done  = s1_reg.flush;
    end

    always_comb
    begin
        status.take       = take;
        status.final_go   = go && s1_reg.final_cell;
        status.final_held = s1_valid_reg && s1_reg.final_cell;
        wr_en             = go && !s1_reg.flush;
        wr_addr           = s1_reg.col;
        wr_data           = {one_bit, s1_reg.mine};
        push0             = go && (emit_a || emit_b);
        push1             = go && emit_a && emit_b;
        res0              = emit_a ? res_a : res_b;
        res1              = res_b;
        s1_valid_next     = take ? issue.valid : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && issue.valid)
        begin
            s1_reg <= issue;
        end
        if (go)
        begin
            m2_reg <= m1_reg;
            m1_reg <= colsum;
        end
    end

endmodule

### design/bgnc_result_fifo.sv
// Result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps

module bgnc_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push0,
    input  logic              push1,
    input  bgnc_pkg::result_t res0,
    input  bgnc_pkg::result_t res1,
    input  logic              pop,
    output logic              room2,
    output logic              not_empty,
    output bgnc_pkg::result_t head
);
    import bgnc_pkg::*;

    result_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg;
    logic [FIFO_CNT_W-1:0]   cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                    - FIFO_CNT_W'(pop);
        room2       = cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
        not_empty   = cnt_reg != '0;
        head        = fifo_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            fifo_mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= res1;
        end
    end

endmodule

### design/binary_grid_neighbor_count.sv
// Top level: 3x3 box count over a streamed square bit grid.
// An accepted input is registered in the window stage, which writes the counts it releases into the result queue.
// Throughput: one input per cycle with the output free; apart from the flush below, an input
// waits only while the result queue holds more than two counts. After the final input of a grid,
// input is held while the last row flushes from the line memory.
// Reset clears position, queue and control and sets grid_size to 8; row masks hide stale lines.
`timescale 1ns / 1ps

module binary_grid_neighbor_count (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  bgnc_pkg::size_t       cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  is_mine,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bgnc_pkg::count_t      mine_count,
    output bgnc_pkg::pos_t        cell_row,
    output bgnc_pkg::pos_t        cell_col,
    output logic                  last_of_run,
    output logic                  field_done
);
    import bgnc_pkg::*;

    size_t       grid_size_reg;
    size_t       grid_size_next;
    pos_t        pos_row_reg;
    pos_t        pos_row_next;
    pos_t        pos_col_reg;
    pos_t        pos_col_next;
    logic        flush_active_reg;
    logic        flush_active_next;
    pos_t        flush_col_reg;
    pos_t        flush_col_next;

    size_t       n_use;
    pos_t        last_idx;
    pos_t        row_cur;
    pos_t        col_cur;
    logic        in_accept;
    logic        flush_issue;
    logic        final_cell;
    logic        last_col;
    issue_t      issue;
    win_status_t status;
    line_t       rd_data;
    logic        wr_en;
    pos_t        wr_addr;
    line_t       wr_data;
    logic        push0;
    logic        push1;
    result_t     res0;
    result_t     res1;
    logic        room2;
    logic        not_empty;
    result_t     head;
    logic        pop;

    always_comb
    begin
        if (grid_size_reg == '0)
        begin
            n_use = SIZE_W'(1);
        end
        else if (grid_size_reg > SIZE_W'(MAX_SIZE))
        begin
            n_use = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            n_use = grid_size_reg;
        end
        last_idx = POS_W'(n_use - SIZE_W'(1));

        if ((SIZE_W'(pos_row_reg) >= n_use) || (SIZE_W'(pos_col_reg) >= n_use))
        begin
            row_cur = '0;
            col_cur = '0;
        end
        else
        begin
            row_cur = pos_row_reg;
            col_cur = pos_col_reg;
        end

        last_col   = col_cur == last_idx;
        final_cell = (row_cur == last_idx) && last_col;

        in_stall    = !status.take || flush_active_reg || status.final_held;
        in_accept   = in_valid && !in_stall;
        flush_issue = flush_active_reg && status.take;

        if (flush_issue)
        begin
            issue.valid      = 1'b1;
            issue.flush      = 1'b1;
            issue.col        = flush_col_reg;
            issue.row        = last_idx;
            issue.mine       = 1'b0;
            issue.emit       = 1'b1;
            issue.last_col   = flush_col_reg == last_idx;
            issue.final_cell = 1'b0;
            issue.mask_one   = 1'b0;
            issue.mask_two   = 1'b0;
        end
        else
        begin
            issue.valid      = in_accept;
            issue.flush      = 1'b0;
            issue.col        = col_cur;
            issue.row        = row_cur - POS_W'(1);
            issue.mine       = is_mine;
            issue.emit       = row_cur != '0;
            issue.last_col   = last_col;
            issue.final_cell = final_cell;
            issue.mask_one   = row_cur == '0;
            issue.mask_two   = row_cur[POS_W-1:1] == '0;
        end
    end

    always_comb
    begin
        grid_size_next    = grid_size_reg;
        pos_row_next      = pos_row_reg;
        pos_col_next      = pos_col_reg;
        flush_active_next = flush_active_reg;
        flush_col_next    = flush_col_reg;

        if (cfg_wr_en)
        begin
            grid_size_next    = cfg_wr_data;
            pos_row_next      = '0;
            pos_col_next      = '0;
            flush_active_next = 1'b0;
            flush_col_next    = '0;
        end
        else
        begin
            if (in_accept)
            begin
                if (final_cell)
                begin
                    pos_row_next = '0;
                    pos_col_next = '0;
                end
                else if (last_col)
                begin
                    pos_row_next = row_cur + POS_W'(1);
                    pos_col_next = '0;
                end
                else
                begin
                    pos_row_next = row_cur;
                    pos_col_next = col_cur + POS_W'(1);
                end
            end
            if (status.final_go)
            begin
                flush_active_next = 1'b1;
                flush_col_next    = '0;
            end
            else if (flush_issue)
            begin
                flush_col_next = flush_col_reg + POS_W'(1);
                if (flush_col_reg == last_idx)
                begin
                    flush_active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg    <= GRID_SIZE_RST;
            pos_row_reg      <= '0;
            pos_col_reg      <= '0;
            flush_active_reg <= 1'b0;
            flush_col_reg    <= '0;
        end
        else
        begin
            grid_size_reg    <= grid_size_next;
            pos_row_reg      <= pos_row_next;
            pos_col_reg      <= pos_col_next;
            flush_active_reg <= flush_active_next;
            flush_col_reg    <= flush_col_next;
        end
    end

    bgnc_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (issue.valid),
        .rd_addr (issue.col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bgnc_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .rd_data (rd_data),
        .room2   (room2),
        .status  (status),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .push0   (push0),
        .push1   (push1),
        .res0    (res0),
        .res1    (res1)
    );

    assign pop = not_empty && !out_stall;

    bgnc_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .res0      (res0),
        .res1      (res1),
        .pop       (pop),
        .room2     (room2),
        .not_empty (not_empty),
        .head      (head)
    );

    assign out_valid   = not_empty;
    assign mine_count  = head.mine_count;
    assign cell_row    = head.cell_row;
    assign cell_col    = head.cell_col;
    assign last_of_run = head.last_of_run;
    assign field_done  = head.field_done;

endmodule

### design/bgnc_checker.sv
// Port-level checker for the grid neighbor count block, bound to the top level.
`timescale 1ns / 1ps

module bgnc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input bgnc_pkg::count_t mine_count,
    input bgnc_pkg::pos_t   cell_row,
    input bgnc_pkg::pos_t   cell_col,
    input logic             last_of_run,
    input logic             field_done
);
    import bgnc_pkg::*;

    localparam count_t MAX_COUNT = COUNT_W'(9);

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_done |-> last_of_run)
        else $error("field_done without last_of_run");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mine_count <= MAX_COUNT)
        else $error("mine_count above nine");

    a_done_on_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_done |-> cell_row == cell_col)
        else $error("field_done off the final corner cell");

    a_new_grid_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && field_done |=>
            !out_valid || (cell_row == '0 && cell_col == '0))
        else $error("next grid does not start at the origin cell");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({mine_count, cell_row, cell_col, last_of_run, field_done}))
        else $error("stalled result transaction changed");

endmodule

bind binary_grid_neighbor_count bgnc_checker u_bgnc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mine_count  (mine_count),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .last_of_run (last_of_run),
    .field_done  (field_done)
);

### tb/tb_binary_grid_neighbor_count.sv
// Self-checking testbench for the streamed 3x3 box count over a square bit grid.
`timescale 1ns / 1ps

module tb_binary_grid_neighbor_count;
    import bgnc_pkg::*;

    localparam int RANDOM_CELLS  = 420;
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_REPORTS   = 40;

    typedef enum logic {ROW_CFG, ROW_CELL} row_kind_e;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

    typedef struct {
        row_kind_e  kind;
        logic [5:0] value;
        logic       typed;
        result_t    want;
    } plan_row_t;

    localparam logic [5:0] EDGE_SIZES [5] = '{6'd32, 6'd63, 6'd33, 6'd0, 6'd1};
    localparam int DENSITIES [5] = '{0, 25, 50, 75, 100};

    plan_row_t plan [29] = '{
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b1, '{4'd0, 5'd0, 5'd0, 1'b1, 1'b0}},
        '{ROW_CFG,  6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b1, '{4'd1, 5'd0, 5'd0, 1'b1, 1'b1}},
        '{ROW_CELL, 6'd0, 1'b1, '{4'd0, 5'd0, 5'd0, 1'b1, 1'b1}},
        '{ROW_CFG,  6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b1, '{4'd1, 5'd0, 5'd0, 1'b1, 1'b1}},
        '{ROW_CFG,  6'd3, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b1, '{4'd4, 5'd0, 5'd0, 1'b1, 1'b0}},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b1, '{4'd6, 5'd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CFG,  6'd63, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b0, '0},
        '{ROW_CELL, 6'd0, 1'b0, '0},
        '{ROW_CELL, 6'd1, 1'b0, '0}
    };

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    size_t      cfg_wr_data = '0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       is_mine     = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    count_t     mine_count;
    pos_t       cell_row;
    pos_t       cell_col;
    logic       last_of_run;
    logic       field_done;

    logic [5:0]  size_reg = GRID_SIZE_RST;
    logic [31:0] row_two  = '0;
    logic [31:0] row_one  = '0;
    logic [31:0] row_fill = '0;
    int unsigned at_row   = 0;
    int unsigned at_col   = 0;

    result_t     released [MAX_SIZE + 2];
    result_t     counts_due [$];
    result_t     head;
    int          mismatches = 0;
    int          burst_left = 0;

    stall_mode_e stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          stall_tick = 0;

    binary_grid_neighbor_count i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .is_mine     (is_mine),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mine_count  (mine_count),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .last_of_run (last_of_run),
        .field_done  (field_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned active_size(input logic [5:0] code);
        if (code == 6'd0)
            return 1;
        if (code > MAX_SIZE)
            return MAX_SIZE;
        return {26'd0, code};
    endfunction

    function automatic int unsigned window_row(input logic [31:0] bits, input int c);
        int unsigned s;
        s = 0;
        for (int k = c - 1; k <= c + 1; k++)
            if (k >= 0 && k < 32)
                s += 32'(bits[k]);
        return s;
    endfunction

    function automatic int unsigned middle_sum(input int c);
        return window_row(row_two, c) + window_row(row_one, c) + window_row(row_fill, c);
    endfunction

    task automatic clear_grid();
        row_two  = '0;
        row_one  = '0;
        row_fill = '0;
        at_row   = 0;
        at_col   = 0;
    endtask

    task automatic predict_cell(input logic mine, output int k);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        logic        last_cell;
        n = active_size(size_reg);
        if (at_row >= n || at_col >= n)
            clear_grid();
        r = at_row;
        c = at_col;
        k = 0;
        if (mine)
            row_fill[c] = 1'b1;
        last_cell = (r == n - 1) && (c == n - 1);
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                released[k] = '{count_t'(middle_sum(c - 1)), pos_t'(r - 1), pos_t'(c - 1),
                                1'b0, 1'b0};
                k++;
            end
            if (c == n - 1)
            begin
                released[k] = '{count_t'(middle_sum(c)), pos_t'(r - 1), pos_t'(c), 1'b0, 1'b0};
                k++;
            end
        end
        if (last_cell)
        begin
            for (int col = 0; col < n; col++)
            begin
                released[k] = '{count_t'(window_row(row_one, col) + window_row(row_fill, col)),
                                pos_t'(r), pos_t'(col), 1'b0, 1'b0};
                k++;
            end
            released[k - 1].field_done = 1'b1;
        end
        if (k > 0)
            released[k - 1].last_of_run = 1'b1;
        if (last_cell)
            clear_grid();
        else if (c == n - 1)
        begin
            row_two  = row_one;
            row_one  = row_fill;
            row_fill = '0;
            at_row   = r + 1;
            at_col   = 0;
        end
        else
            at_col = c + 1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // hold off until every count has arrived and the flush has settled
    task automatic write_grid_size(input logic [5:0] code);
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (counts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        size_reg = code;
        clear_grid();
    endtask

    task automatic push_cell(input logic mine, input logic typed, input result_t want);
        int gap;
        int k;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        is_mine  <= mine;
        do
            @(posedge clk);
        while (in_stall);
        predict_cell(mine, k);
        if (typed)
            counts_due = {counts_due, want};
        else
            for (int j = 0; j < k; j++)
                counts_due = {counts_due, released[j]};
    endtask

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= ((stall_tick % 9) < 5);
            default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (counts_due.size() == 0)
                report_mismatch("transaction with nothing pending", int'(mine_count), -1);
            else
            begin
                head = counts_due.pop_front();
                if (mine_count !== head.mine_count)
                    report_mismatch("mine_count", int'(mine_count), int'(head.mine_count));
                if (cell_row !== head.cell_row)
                    report_mismatch("cell_row", int'(cell_row), int'(head.cell_row));
                if (cell_col !== head.cell_col)
                    report_mismatch("cell_col", int'(cell_col), int'(head.cell_col));
                if (last_of_run !== head.last_of_run)
                    report_mismatch("last_of_run", int'(last_of_run), int'(head.last_of_run));
                if (field_done !== head.field_done)
                    report_mismatch("field_done", int'(field_done), int'(head.field_done));
            end
        end
    end

    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int         cells_sent;
        int         phase;
        int         n;
        int         cells;
        int         density;
        logic [5:0] code;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(plan); i++)
        begin
            if (plan[i].kind == ROW_CFG)
                write_grid_size(plan[i].value);
            else
                push_cell(plan[i].value[0], plan[i].typed, plan[i].want);
        end

        cells_sent = 0;
        phase = 0;
        while (cells_sent < RANDOM_CELLS)
        begin
            if (phase < $size(EDGE_SIZES))
                code = EDGE_SIZES[phase];
            else
            begin
                case ($urandom_range(0, 9))
                    0:       code = 6'($urandom_range(0, 63));
                    1:       code = 6'($urandom_range(13, 32));
                    default: code = 6'($urandom_range(1, 9));
                endcase
            end
            phase++;
            write_grid_size(code);
            n = active_size(code);
            // large grids are cut short; small ones run whole, often more than once
            if (n > 12)
                cells = n * $urandom_range(1, 2) + $urandom_range(0, n - 1);
            else
                cells = n * n * $urandom_range(1, 3) +
                        (($urandom_range(0, 3) == 0) ? $urandom_range(0, n * n - 1) : 0);
            if (cells > RANDOM_CELLS - cells_sent)
                cells = RANDOM_CELLS - cells_sent;
            density = DENSITIES[$urandom_range(0, 4)];
            repeat (cells) push_cell($urandom_range(0, 99) < density, 1'b0, '0);
            cells_sent += cells;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (counts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
